@@ sv/tsq_pkg.sv @@
package tsq_pkg;

   localparam int REQ_W   = 3;
   localparam int ID_W    = 16;
   localparam int DWELL_W = 16;
   localparam int KIND_W  = 2;
   localparam int ENTRY_W = ID_W + DWELL_W;

   // request codes
   localparam logic [REQ_W-1:0] REQ_ENQUEUE    = 3'd0;
   localparam logic [REQ_W-1:0] REQ_DEQUEUE    = 3'd1;
   localparam logic [REQ_W-1:0] REQ_REMOVE_ALL = 3'd2;
   localparam logic [REQ_W-1:0] REQ_KEEP_HEAD  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_TICK       = 3'd4;

   // event kinds
   localparam logic [KIND_W-1:0] EV_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] EV_ENTERED = 2'd1;
   localparam logic [KIND_W-1:0] EV_EXITED  = 2'd2;

   typedef struct packed {
      logic load;         // capture the request beat
      logic exec;         // apply the request to the queue
      logic emit_second;  // present the entered event of an expiring tick
   } ctl_cmd_type;

   typedef struct packed {
      logic has_second;   // request produces a second result beat
   } dp_status_type;

endpackage

@@ sv/timed_state_queue.sv @@
// Timed state queue: a FIFO of up to QUEUE_DEPTH (state id, dwell) entries
// with an elapsed-tick counter for the head. Raise start with a request beat
// while busy is low; the beat is taken at that edge and busy stays high until
// the request is done. Each request yields one result beat, or two for a tick
// that expires the head while another entry remains (exited, then entered).
// Result beats appear on consecutive cycles, each marked by rsp_strobe for
// exactly one cycle, with rsp_last set on the final one; there is no way to
// stall them, so sample every strobe. A request occupies the block for four
// clock cycles, five when it gives two results, and start may be raised again
// on the cycle after the last result. That figure is set by the entry store:
// the head is read through a registered read port, so after each update the
// new head needs one cycle to reach the read register before results go out.
// Reset clears pointers, occupancy and counter in one cycle; the entry store
// itself is never cleared, since only written entries are read.
module timed_state_queue import tsq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [REQ_W-1:0]                 req_type,
   input  logic [ID_W-1:0]                  req_state_id,
   input  logic [DWELL_W-1:0]               req_dwell_ticks,
   output logic                             rsp_strobe,
   output logic [KIND_W-1:0]                rsp_event_kind,
   output logic [ID_W-1:0]                  rsp_event_state,
   output logic [ID_W-1:0]                  rsp_head_state,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] rsp_entry_count,
   output logic                             rsp_error,
   output logic                             rsp_last
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   // sequence capture, update, head fetch and result beats
   tsq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   // hold the entry store, pointers, counter and event payload
   tsq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req_type),
      .req_state_id    (req_state_id),
      .req_dwell_ticks (req_dwell_ticks),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_state (rsp_event_state),
      .rsp_head_state  (rsp_head_state),
      .rsp_entry_count (rsp_entry_count),
      .rsp_error       (rsp_error),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTHESIS
   // a first beat that is not last is followed at once by the closing beat
   a_pair_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe && rsp_last)
      else $error("second result beat missing after non-final beat");

   // results only go out while a request is in flight
   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result beat while idle");

   // the closing beat releases the block
   a_last_releases: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !busy)
      else $error("block still busy after final result beat");

   // occupancy never exceeds the queue depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_entry_count <= QUEUE_DEPTH)
      else $error("entry count beyond queue depth");
`endif

endmodule

@@ sv/tsq_ctrl.sv @@
module tsq_ctrl import tsq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_strobe,
   output ctl_cmd_type   cmd,
   input  dp_status_type status
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_WAIT  = 3'd2;
   localparam logic [2:0] ST_EMIT1 = 3'd3;
   localparam logic [2:0] ST_EMIT2 = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC:  state_in = ST_WAIT;
         ST_WAIT:  state_in = ST_EMIT1;
         ST_EMIT1: begin
            state_in = status.has_second ? ST_EMIT2 : ST_IDLE;
         end
         ST_EMIT2: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = (state_ff == ST_EMIT1) || (state_ff == ST_EMIT2);
   assign cmd.load        = start && (state_ff == ST_IDLE);
   assign cmd.exec        = (state_ff == ST_EXEC);
   assign cmd.emit_second = (state_ff == ST_EMIT2);

endmodule

@@ sv/tsq_datapath.sv @@
module tsq_datapath import tsq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ctl_cmd_type                      cmd,
   output dp_status_type                    status,
   input  logic [REQ_W-1:0]                 req_type,
   input  logic [ID_W-1:0]                  req_state_id,
   input  logic [DWELL_W-1:0]               req_dwell_ticks,
   output logic [KIND_W-1:0]                rsp_event_kind,
   output logic [ID_W-1:0]                  rsp_event_state,
   output logic [ID_W-1:0]                  rsp_head_state,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] rsp_entry_count,
   output logic                             rsp_error,
   output logic                             rsp_last
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W+1)'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;

   logic [REQ_W-1:0]   req_ff;
   logic [ID_W-1:0]    sid_ff;
   logic [DWELL_W-1:0] dwell_ff;

   logic [PTR_W-1:0]   rd_ptr_ff,  rd_ptr_in;
   logic [CNT_W-1:0]   occ_ff,     occ_in;
   logic [DWELL_W-1:0] elapsed_ff, elapsed_in;
   logic [KIND_W-1:0]  ev_kind_ff, ev_kind_in;
   logic [ID_W-1:0]    ev_state_ff, ev_state_in;
   logic               err_ff,     err_in;
   logic               second_ff,  second_in;
   logic               mem_we;

   logic [ID_W-1:0]    head_id;
   logic [DWELL_W-1:0] head_dwell;
   logic [CNT_W:0]     tail_sum;
   logic [CNT_W:0]     tail_wrap;
   logic [PTR_W-1:0]   tail_ptr;
   logic [PTR_W-1:0]   next_ptr;
   logic [DWELL_W-1:0] elapsed_sat;
   logic               empty;

   assign head_id    = rdata_ff[ENTRY_W-1:DWELL_W];
   assign head_dwell = rdata_ff[DWELL_W-1:0];
   assign empty      = (occ_ff == '0);

   assign tail_sum  = (CNT_W+1)'(rd_ptr_ff) + (CNT_W+1)'(occ_ff);
   assign tail_wrap = (tail_sum >= DEPTH_EXT) ? (tail_sum - DEPTH_EXT) : tail_sum;
   assign tail_ptr  = tail_wrap[PTR_W-1:0];
   assign next_ptr  = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;

   assign elapsed_sat = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;

   always_comb begin
      rd_ptr_in   = rd_ptr_ff;
      occ_in      = occ_ff;
      elapsed_in  = elapsed_ff;
      ev_kind_in  = EV_NONE;
      ev_state_in = '0;
      err_in      = 1'b0;
      second_in   = 1'b0;
      mem_we      = 1'b0;
      case (req_ff)
         REQ_ENQUEUE: begin
            if (occ_ff == FULL_CNT) begin
               err_in = 1'b1;
            end else begin
               mem_we = 1'b1;
               occ_in = occ_ff + 1'b1;
               if (empty) begin
                  ev_kind_in  = EV_ENTERED;
                  ev_state_in = sid_ff;
               end
            end
         end
         REQ_DEQUEUE: begin
            if (empty) begin
               err_in = 1'b1;
            end else begin
               ev_kind_in  = EV_EXITED;
               ev_state_in = head_id;
               rd_ptr_in   = next_ptr;
               occ_in      = occ_ff - 1'b1;
               elapsed_in  = '0;
            end
         end
         REQ_REMOVE_ALL: begin
            if (empty) begin
               err_in = 1'b1;
            end else begin
               ev_kind_in  = EV_EXITED;
               ev_state_in = head_id;
               occ_in      = '0;
               elapsed_in  = '0;
            end
         end
         REQ_KEEP_HEAD: begin
            if (empty) begin
               err_in = 1'b1;
            end else begin
               occ_in = CNT_W'(1);
            end
         end
         REQ_TICK: begin
            if (empty) begin
               err_in = 1'b1;
            end else if (head_dwell != '0 && head_dwell == elapsed_sat) begin
               ev_kind_in  = EV_EXITED;
               ev_state_in = head_id;
               rd_ptr_in   = next_ptr;
               occ_in      = occ_ff - 1'b1;
               elapsed_in  = '0;
               second_in   = (occ_ff > CNT_W'(1));
            end else begin
               elapsed_in = elapsed_sat;
            end
         end
         default: begin
            err_in = 1'b0;
         end
      endcase
   end

   // entry store: tail write, head read, read data registered every cycle
   always_ff @(posedge clock) begin
      if (cmd.exec && mem_we) begin
         mem[tail_ptr] <= {sid_ff, dwell_ff};
      end
      rdata_ff <= mem[rd_ptr_ff];
   end

   // request beat and event payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_type;
         sid_ff   <= req_state_id;
         dwell_ff <= req_dwell_ticks;
      end
      if (cmd.exec) begin
         ev_kind_ff  <= ev_kind_in;
         ev_state_ff <= ev_state_in;
         err_ff      <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff  <= '0;
         occ_ff     <= '0;
         elapsed_ff <= '0;
         second_ff  <= 1'b0;
      end else if (cmd.exec) begin
         rd_ptr_ff  <= rd_ptr_in;
         occ_ff     <= occ_in;
         elapsed_ff <= elapsed_in;
         second_ff  <= second_in;
      end
   end

   assign status.has_second = second_ff;

   assign rsp_event_kind  = cmd.emit_second ? EV_ENTERED : ev_kind_ff;
   assign rsp_event_state = cmd.emit_second ? head_id : ev_state_ff;
   assign rsp_head_state  = empty ? '0 : head_id;
   assign rsp_entry_count = occ_ff;
   assign rsp_error       = err_ff;
   assign rsp_last        = cmd.emit_second || !second_ff;

endmodule
